[src/dle_pkg.sv]
// ----------------------------------------------------------------------------
// dle_pkg
// Shared constants and types for the DLE STX/ETX deframer.
// ----------------------------------------------------------------------------
package dle_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CNT_W  = 11;

  localparam logic [BYTE_W-1:0] DLE = 8'h10;
  localparam logic [BYTE_W-1:0] STX = 8'h02;
  localparam logic [BYTE_W-1:0] ETX = 8'h03;

  // Stored payload limit per frame; must fit in CNT_W bits
  localparam logic [CNT_W-1:0] MAX_FRAME_LEN = 11'd1024;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_ABORT   = 2'd2
  } dle_kind_e;

endpackage

[src/dle_if.sv]
// ----------------------------------------------------------------------------
// dle_in_if / dle_out_if
// Valid/ready channels for raw link bytes and deframer results.
// ----------------------------------------------------------------------------
interface dle_in_if import dle_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dle_out_if import dle_pkg::*;;
  logic              valid;
  logic              ready;
  dle_kind_e         result_kind;
  logic [BYTE_W-1:0] payload_byte;
  logic [CNT_W-1:0]  frame_length;
  logic              overflowed;

  modport source (output valid, output result_kind, output payload_byte,
                  output frame_length, output overflowed, input ready);
  modport sink   (input valid, input result_kind, input payload_byte,
                  input frame_length, input overflowed, output ready);
endinterface

[src/dle_stx_etx_deframer.sv]
// ----------------------------------------------------------------------------
// dle_stx_etx_deframer
// Removes DLE byte stuffing from DLE STX ... DLE ETX frames, one byte a beat.
// ----------------------------------------------------------------------------
// An accepted byte passes the input stage, then the result register, to its result beat.
// Throughput: 1 byte per cycle while the result is not stalled; the frame state update is one short step.
// A stalled result holds only the result register; the input stage keeps
//   taking bytes until it too holds a byte that has a result to deliver.
// Reset (rst_ni low, async): outside any frame, no escape, count cleared,
//   both stages empty.
module dle_stx_etx_deframer import dle_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  dle_in_if.sink     in_i,
  dle_out_if.source  out_o
);

  // Input stage
  logic              s1_valid_q;
  logic [BYTE_W-1:0] s1_byte_q;

  // Frame state
  logic             in_frame_q, in_frame_d;
  logic             esc_q, esc_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             ovf_q, ovf_d;

  // Result register
  logic              out_valid_q;
  dle_kind_e         kind_q, kind_d;
  logic [BYTE_W-1:0] pbyte_q, pbyte_d;
  logic [CNT_W-1:0]  len_q, len_d;
  logic              oflag_q, oflag_d;

  logic emit;
  logic out_free;
  logic s1_adv;
  logic in_fire;

  always_comb begin
    in_frame_d = in_frame_q;
    esc_d      = esc_q;
    cnt_d      = cnt_q;
    ovf_d      = ovf_q;
    emit       = 1'b0;
    kind_d     = KIND_PAYLOAD;
    pbyte_d    = '0;
    len_d      = cnt_q;
    oflag_d    = 1'b0;

    if (!in_frame_q) begin
      // Outside a frame only DLE STX matters; drop everything else
      if (esc_q) begin
        esc_d = 1'b0;
        if (s1_byte_q == STX) begin
          in_frame_d = 1'b1;
          cnt_d      = '0;
          ovf_d      = 1'b0;
        end
      end else if (s1_byte_q == DLE) begin
        esc_d = 1'b1;
      end
    end else if (esc_q && s1_byte_q == ETX) begin
      esc_d      = 1'b0;
      emit       = 1'b1;
      kind_d     = KIND_DONE;
      oflag_d    = ovf_q;
      in_frame_d = 1'b0;
      cnt_d      = '0;
      ovf_d      = 1'b0;
    end else if (esc_q && s1_byte_q == STX) begin
      esc_d   = 1'b0;
      emit    = 1'b1;
      kind_d  = KIND_ABORT;
      oflag_d = ovf_q;
      cnt_d   = '0;
      ovf_d   = 1'b0;
    end else if (!esc_q && s1_byte_q == DLE) begin
      esc_d = 1'b1;
    end else begin
      // Payload byte, plain or escaped
      esc_d = 1'b0;
      if (cnt_q >= MAX_FRAME_LEN) begin
        ovf_d = 1'b1;
      end else begin
        emit    = 1'b1;
        pbyte_d = s1_byte_q;
        cnt_d   = cnt_q + CNT_W'(1);
      end
    end
  end

  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_adv     = s1_valid_q && (!emit || out_free);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_fire    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      in_frame_q  <= 1'b0;
      esc_q       <= 1'b0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s1_adv) begin
        in_frame_q <= in_frame_d;
        esc_q      <= esc_d;
        cnt_q      <= cnt_d;
        ovf_q      <= ovf_d;
      end
      if (out_free) begin
        out_valid_q <= s1_adv && emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= in_i.rx_byte;
    end
    if (out_free && s1_adv && emit) begin
      kind_q  <= kind_d;
      pbyte_q <= pbyte_d;
      len_q   <= len_d;
      oflag_q <= oflag_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_kind  = kind_q;
  assign out_o.payload_byte = pbyte_q;
  assign out_o.frame_length = len_q;
  assign out_o.overflowed   = oflag_q;

  // Count never runs past the stored-byte limit
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MAX_FRAME_LEN)
    else $error("byte count beyond frame limit");

  // Outside a frame the count and overflow flag stay cleared
  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_frame_q |-> (cnt_q == '0 && !ovf_q))
    else $error("frame state not cleared outside frame");

  // Payload beats never carry the overflow flag
  a_payload_noovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q == KIND_PAYLOAD) |-> !oflag_q)
    else $error("overflow flag on payload beat");

  // A held result is not overwritten while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=>
      (out_valid_q && $stable(kind_q) && $stable(len_q) && $stable(pbyte_q)))
    else $error("stalled result changed");

endmodule

[bench/dle_stx_etx_deframer_tb.sv]
// ----------------------------------------------------------------------------
// dle_stx_etx_deframer_tb
// Drives raw link bytes into the deframer through the valid/ready channels,
// tracks the framing state alongside it and checks every result beat in
// order: payload bytes with their positions, closed and abandoned frames with
// their lengths and overflow flags. Both sides idle at random, the receiver
// holds off once for a long stretch, and one frame runs past the length cap.
// ----------------------------------------------------------------------------
module dle_stx_etx_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dle_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RX_HOLD_LEN = 300;
  localparam int unsigned ITEM_TARGET = 1500;
  localparam int unsigned REPORT_MAX  = 10;

  typedef struct packed {
    dle_kind_e         kind;
    logic [BYTE_W-1:0] payload;
    logic [CNT_W-1:0]  frame_len;
    logic              ovf;
  } deframe_beat_t;

  // Tracks the frame state and queues the beats each raw byte should produce
  class deframe_scoreboard;
    bit               in_frame;
    bit               dle_armed;
    logic [CNT_W-1:0] stored;
    bit               dropped;
    deframe_beat_t    awaited[$];
    int unsigned      errors;
    int unsigned      payload_beats;
    int unsigned      done_beats;
    int unsigned      abort_beats;
    int unsigned      overflow_reports;

    function void store_payload(logic [BYTE_W-1:0] b);
      if (stored >= MAX_FRAME_LEN) begin
        dropped = 1'b1;
        return;
      end
      awaited.push_back('{kind: KIND_PAYLOAD, payload: b, frame_len: stored,
                          ovf: 1'b0});
      stored++;
    endfunction

    function void take_rx_byte(logic [BYTE_W-1:0] b);
      if (!in_frame) begin
        if (dle_armed) begin
          dle_armed = 1'b0;
          if (b == STX) begin
            in_frame = 1'b1;
            stored   = '0;
            dropped  = 1'b0;
          end
        end else if (b == DLE) begin
          dle_armed = 1'b1;
        end
      end else if (dle_armed) begin
        dle_armed = 1'b0;
        if (b == ETX) begin
          awaited.push_back('{kind: KIND_DONE, payload: '0, frame_len: stored,
                              ovf: dropped});
          in_frame = 1'b0;
          stored   = '0;
          dropped  = 1'b0;
        end else if (b == STX) begin
          awaited.push_back('{kind: KIND_ABORT, payload: '0, frame_len: stored,
                              ovf: dropped});
          stored  = '0;
          dropped = 1'b0;
        end else begin
          store_payload(b);
        end
      end else if (b == DLE) begin
        dle_armed = 1'b1;
      end else begin
        store_payload(b);
      end
    endfunction

    function void check_beat(deframe_beat_t got);
      deframe_beat_t want;
      bit            bad;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("[%0t] unexpected beat: kind=%0d byte=%02h len=%0d ovf=%0d",
                   $realtime, got.kind, got.payload, got.frame_len, got.ovf);
        return;
      end
      want = awaited.pop_front();
      bad  = (got.kind !== want.kind) || (got.payload !== want.payload) ||
             (got.frame_len !== want.frame_len) || (got.ovf !== want.ovf);
      if (bad) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("[%0t] mismatch: exp k=%0d b=%02h l=%0d o=%0d, got k=%0d b=%02h l=%0d o=%0d",
                   $realtime, want.kind, want.payload, want.frame_len, want.ovf,
                   got.kind, got.payload, got.frame_len, got.ovf);
        return;
      end
      case (want.kind)
        KIND_PAYLOAD: payload_beats++;
        KIND_DONE:    done_beats++;
        default:      abort_beats++;
      endcase
      if (want.ovf) overflow_reports++;
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  dle_in_if  in_bus ();
  dle_out_if out_bus ();

  dle_stx_etx_deframer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  deframe_scoreboard board = new();

  bit          no_gaps;
  int unsigned rx_hold_left;
  int unsigned cycle_count;
  int unsigned sent_count;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count++;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles", cycle_count);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Receiver: ready changes on the falling edge, beats are taken on the rising edge
  always @(negedge clk_i) begin
    if (rx_hold_left != 0) begin
      out_bus.ready = 1'b0;
      rx_hold_left--;
    end else begin
      out_bus.ready = no_gaps || ($urandom_range(99) >= 37);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready)
      board.check_beat('{kind: out_bus.result_kind, payload: out_bus.payload_byte,
                         frame_len: out_bus.frame_length, ovf: out_bus.overflowed});
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    if (!no_gaps) begin
      while ($urandom_range(99) < 37) begin
        in_bus.valid = 1'b0;
        @(negedge clk_i);
      end
    end
    in_bus.valid   = 1'b1;
    in_bus.rx_byte = b;
    do @(posedge clk_i); while (!in_bus.ready);
    board.take_rx_byte(b);
    sent_count++;
    @(negedge clk_i);
  endtask

  task automatic send_frame(input int unsigned n, input bit close);
    int unsigned       r;
    logic [BYTE_W-1:0] x;
    send_byte(DLE);
    send_byte(STX);
    for (int unsigned k = 0; k < n; k++) begin
      r = $urandom_range(99);
      x = $urandom_range(255);
      if (r < 12) begin
        send_byte(DLE);
        send_byte(DLE);
      end else if (r < 20) begin
        // escaped ordinary byte: keep it away from STX and ETX
        if (x == STX || x == ETX) x ^= 8'h40;
        send_byte(DLE);
        send_byte(x);
      end else if (r < 25) begin
        send_byte(x[0] ? STX : ETX);
      end else if (x == DLE) begin
        send_byte(DLE);
        send_byte(DLE);
      end else begin
        send_byte(x);
      end
    end
    if (close) begin
      send_byte(DLE);
      send_byte(ETX);
    end
  endtask

  task automatic send_noise(input int unsigned n);
    for (int unsigned k = 0; k < n; k++) send_byte($urandom_range(255));
  endtask

  task automatic wait_drained();
    in_bus.valid = 1'b0;
    while (board.awaited.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    int unsigned p;
    in_bus.valid   = 1'b0;
    in_bus.rx_byte = '0;
    out_bus.ready  = 1'b0;
    rst_ni         = 1'b0;
    no_gaps        = 1'b0;
    rx_hold_left   = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // outside a frame: lone bytes, a skipped DLE pair, DLE DLE STX must not open
    send_byte(8'hFF);
    send_byte(DLE);
    send_byte(8'h41);
    send_byte(DLE);
    send_byte(DLE);
    send_byte(STX);
    // empty frame
    send_byte(DLE);
    send_byte(STX);
    send_byte(DLE);
    send_byte(ETX);
    // byte extremes, stuffed DLE, escaped byte, plain control codes, then abandon
    send_byte(DLE);
    send_byte(STX);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(DLE);
    send_byte(DLE);
    send_byte(DLE);
    send_byte(8'h7E);
    send_byte(STX);
    send_byte(ETX);
    send_byte(DLE);
    send_byte(STX);
    send_byte(8'h55);
    send_byte(DLE);
    send_byte(ETX);
    wait_drained();

    for (int unsigned it = 0; sent_count < ITEM_TARGET; it++) begin
      no_gaps = (it >= 8 && it < 12);
      if (it == 12) begin
        // left open past the cap; the next start abandons it
        send_frame(int'(MAX_FRAME_LEN) + 1, 1'b0);
        send_frame($urandom_range(0, 40), 1'b1);
      end else if (it == 3) begin
        // stall the receiver while the sender keeps offering bytes back to back
        @(posedge clk_i);
        rx_hold_left = RX_HOLD_LEN;
        @(negedge clk_i);
        no_gaps = 1'b1;
        send_frame(30, 1'b1);
        no_gaps = 1'b0;
      end else if (it % 5 == 1) begin
        wait_drained();
      end else if (no_gaps) begin
        send_frame($urandom_range(0, 40), 1'b1);
      end else begin
        p = $urandom_range(99);
        if (p < 10)
          send_noise($urandom_range(1, 6));
        else if (p < 15)
          send_frame($urandom_range(0, 40), 1'b0);
        else
          send_frame($urandom_range(0, 40), 1'b1);
      end
    end
    no_gaps      = 1'b0;
    in_bus.valid = 1'b0;

    while (board.awaited.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (board.awaited.size() != 0) begin
      board.errors += board.awaited.size();
      $display("%0d expected beats never arrived", board.awaited.size());
    end
    $display("Fed %0d link bytes; %0d payload beats, %0d closed, %0d abandoned frames",
             sent_count, board.payload_beats, board.done_beats, board.abort_beats);
    $display("%0d frame reports flagged overflow; receiver stalled once for %0d cycles",
             board.overflow_reports, RX_HOLD_LEN);
    if (board.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
